[src/tlbs_pkg.sv]
// Shared types and constants for the table search unit.
`timescale 1ns / 1ps

package tlbs_pkg;

  localparam int KEY_W = 32;
  localparam int IDX_W = 4;
  localparam int POS_W = 4;
  localparam int OP_W  = 2;

  localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
  localparam logic [OP_W-1:0] OP_LINEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_BINARY = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LIN,
    S_BIN,
    S_FIN
  } state_t;

  typedef struct packed {
    logic                    en;
    logic [IDX_W-1:0]        idx;
    logic signed [KEY_W-1:0] data;
  } tab_wr_t;

endpackage

[src/table_linear_and_binary_search_unit.sv]
// Linear search: one compare per entry, visiting every entry.
// Binary search: one probe per cycle.
// Write and unused operations go straight to the finish state; a new item is accepted only while idle.
// All probes share one table read port and one signed comparator.
// Synchronous active-low reset clears the table and the sequencer.
`timescale 1ns / 1ps

module table_linear_and_binary_search_unit import tlbs_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [OP_W-1:0]         in_operation,
  input  logic [IDX_W-1:0]        in_index,
  input  logic signed [KEY_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_found,
  output logic [POS_W-1:0]        out_position
);

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  state_t                  state_r, state_nxt;
  logic [AW-1:0]           ctr_r, ctr_nxt;
  logic [CW-1:0]           lo_r, lo_nxt;
  logic [CW-1:0]           hp_r, hp_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic                    hit_r, hit_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    found_r, found_nxt;
  logic [POS_W-1:0]        position_r, position_nxt;

  tab_wr_t                 wr;
  logic [AW-1:0]           rd_addr;
  logic signed [KEY_W-1:0] rd_data;
  logic [CW:0]             mid_sum;
  logic [AW-1:0]           mid;
  logic                    eq;
  logic                    less;
  logic                    accept;

  tlbs_table #(.ENTRIES(ENTRIES)) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_stall     = (state_r != S_IDLE);
  assign accept       = in_valid && !in_stall;
  assign out_valid    = out_valid_r;
  assign out_found    = found_r;
  assign out_position = position_r;

  assign wr.en   = accept && (in_operation == OP_WRITE);
  assign wr.idx  = in_index;
  assign wr.data = in_value;

  assign mid_sum = {1'b0, lo_r} + {1'b0, hp_r} - (CW + 1)'(1);
  assign mid     = AW'(mid_sum >> 1);
  assign rd_addr = (state_r == S_LIN) ? ctr_r : mid;
  assign eq      = (rd_data == key_r);
  assign less    = (rd_data < key_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ctr_r      <= ctr_nxt;
    lo_r       <= lo_nxt;
    hp_r       <= hp_nxt;
    key_r      <= key_nxt;
    hit_r      <= hit_nxt;
    pos_r      <= pos_nxt;
    found_r    <= found_nxt;
    position_r <= position_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    ctr_nxt       = ctr_r;
    lo_nxt        = lo_r;
    hp_nxt        = hp_r;
    key_nxt       = key_r;
    hit_nxt       = hit_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && out_stall;
    found_nxt     = found_r;
    position_nxt  = position_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          key_nxt = in_value;
          hit_nxt = 1'b0;
          pos_nxt = '0;
          ctr_nxt = '0;
          lo_nxt  = '0;
          hp_nxt  = CW'(ENTRIES);
          case (in_operation)
            OP_LINEAR: state_nxt = S_LIN;
            OP_BINARY: state_nxt = S_BIN;
            default:   state_nxt = S_FIN;
          endcase
        end
      end
      S_LIN: begin
        if (eq) begin
          hit_nxt = 1'b1;
          pos_nxt = POS_W'(ctr_r);
        end
        if (ctr_r == AW'(ENTRIES - 1)) begin
          state_nxt = S_FIN;
        end else begin
          ctr_nxt = ctr_r + AW'(1);
        end
      end
      S_BIN: begin
        if (lo_r < hp_r) begin
          if (eq) begin
            hit_nxt   = 1'b1;
            pos_nxt   = POS_W'(mid);
            state_nxt = S_FIN;
          end else if (less) begin
            lo_nxt = CW'(mid) + CW'(1);
          end else begin
            hp_nxt = CW'(mid);
          end
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          found_nxt     = hit_r;
          position_nxt  = hit_r ? pos_r : '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_load_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FIN)
    else $error("result word loaded outside finish state");

  a_miss_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !found_r) |-> (position_r == '0))
    else $error("miss word carries nonzero position");

  a_lin_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LIN) |-> (32'(ctr_r) <= 32'(ENTRIES - 1)))
    else $error("linear counter past table end");

  a_bin_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BIN) |-> ((lo_r <= hp_r) && (32'(hp_r) <= 32'(ENTRIES))))
    else $error("binary search range out of bounds");
`endif

endmodule

[src/tlbs_table.sv]
// Entry table: register file with one write port and one read port.
`timescale 1ns / 1ps

module tlbs_table import tlbs_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tab_wr_t                         wr,
  input  logic [$clog2(ENTRIES)-1:0]      rd_addr,
  output logic signed [KEY_W-1:0]         rd_data
);

  localparam int SD  = (ENTRIES < (1 << IDX_W)) ? ENTRIES : (1 << IDX_W);
  localparam int SAW = $clog2(SD);

  logic signed [KEY_W-1:0] mem_r [SD];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SD; i++) begin
        mem_r[i] <= '0;
      end
    end else if (wr.en && (32'(wr.idx) < 32'(SD))) begin
      mem_r[wr.idx[SAW-1:0]] <= wr.data;
    end
  end

  // Entries past the writable range keep their reset value.
  always_comb begin
    if (32'(rd_addr) < 32'(SD)) begin
      rd_data = mem_r[rd_addr[SAW-1:0]];
    end else begin
      rd_data = '0;
    end
  end

endmodule

[sim/tb.sv]
// Self-checking testbench for the table search unit: writes, linear and binary searches.
`timescale 1ns / 1ps

module tb import tlbs_pkg::*; ();

  localparam int ENTRIES = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_PCT = 37;
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;
  localparam int RANDOM_WORDS = 1090;
  localparam int MAX_PRINTS = 50;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } search_result_t;

  logic                    clk;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [OP_W-1:0]         in_operation = OP_WRITE;
  logic [IDX_W-1:0]        in_index = '0;
  logic signed [KEY_W-1:0] in_value = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    out_found;
  logic [POS_W-1:0]        out_position;

  logic signed [KEY_W-1:0] shadow_table [ENTRIES];
  search_result_t          pending_results [$];
  int                      mismatch_count = 0;
  int                      words_sent = 0;
  int                      idle_cycles = 0;
  logic                    calm = 1'b0;
  logic                    hold_on = 1'b0;
  event                    hold_ev;

  table_linear_and_binary_search_unit #(
    .ENTRIES(ENTRIES)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_operation(in_operation),
    .in_index(in_index),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_found(out_found),
    .out_position(out_position)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic search_result_t search_outcome(input logic [OP_W-1:0] op,
                                                    input logic [IDX_W-1:0] idx,
                                                    input logic signed [KEY_W-1:0] key);
    search_result_t r;
    int lo;
    int hi;
    int mid;
    logic done;
    r = '0;
    case (op)
      OP_WRITE: begin
        shadow_table[idx] = key;
      end
      OP_LINEAR: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (shadow_table[i] == key) begin
            r.found = 1'b1;
            r.position = i[POS_W-1:0];
          end
        end
      end
      OP_BINARY: begin
        lo = 0;
        hi = ENTRIES - 1;
        done = 1'b0;
        while (!done && lo <= hi) begin
          mid = (lo + hi) / 2;
          if (shadow_table[mid] == key) begin
            r.found = 1'b1;
            r.position = mid[POS_W-1:0];
            done = 1'b1;
          end else if (shadow_table[mid] < key) begin
            lo = mid + 1;
          end else begin
            hi = mid - 1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // key taken from the table, next to a table entry, or anywhere
  function automatic logic signed [KEY_W-1:0] pick_key();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return shadow_table[$urandom_range(0, ENTRIES - 1)];
    if (sel < 8)
      return shadow_table[$urandom_range(0, ENTRIES - 1)] + ($urandom_range(0, 1) ? 1 : -1);
    return $urandom;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTS)
      $display("%0t mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                           input logic signed [KEY_W-1:0] val);
    if (!calm) begin
      while ($urandom_range(0, 99) < STALL_PCT) begin
        in_valid = 1'b0;
        @(negedge clk);
      end
    end
    in_valid = 1'b1;
    in_operation = op;
    in_index = idx;
    in_value = val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(search_outcome(op, idx, val));
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_search(input logic signed [KEY_W-1:0] key);
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) send_word(OP_UNUSED, IDX_W'($urandom), key);
    else send_word(sel[0] ? OP_LINEAR : OP_BINARY, IDX_W'($urandom), key);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (!rst_n) out_stall = 1'b0;
    else if (hold_on) out_stall = 1'b1;
    else if (calm) out_stall = 1'b0;
    else out_stall = ($urandom_range(0, 99) < STALL_PCT);
  end

  initial begin
    forever begin
      @(hold_ev);
      @(posedge clk);
      hold_on = 1'b1;
      for (int k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
      hold_on = 1'b0;
    end
  end

  always @(posedge clk) begin
    search_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: found=%0b pos=%0d",
                                  out_found, out_position));
      end else begin
        want = pending_results.pop_front();
        if (out_found !== want.found)
          report_mismatch($sformatf("found got %0b want %0b", out_found, want.found));
        if (out_position !== want.position)
          report_mismatch($sformatf("position got %0d want %0d", out_position, want.position));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_cleared_table();
    send_word(OP_LINEAR, 4'd3, 32'sd0);
    send_word(OP_BINARY, 4'd12, 32'sd0);
    send_word(OP_LINEAR, 4'd0, 32'sh8000_0000);
    send_word(OP_BINARY, 4'hF, 32'sh7FFF_FFFF);
  endtask

  task automatic test_extremes_and_unsorted();
    send_word(OP_WRITE, 4'd0, 32'sh8000_0000);
    send_word(OP_WRITE, 4'hF, 32'sh7FFF_FFFF);
    send_word(OP_UNUSED, 4'hF, -32'sd1);
    send_word(OP_UNUSED, 4'd0, 32'sd0);
    send_word(OP_LINEAR, 4'd9, 32'sh8000_0000);
    send_word(OP_LINEAR, 4'd1, 32'sh7FFF_FFFF);
    send_word(OP_LINEAR, 4'd2, -32'sd1);
    send_word(OP_BINARY, 4'd0, 32'sh8000_0000);
    send_word(OP_BINARY, 4'd0, 32'sh7FFF_FFFF);
    send_word(OP_BINARY, 4'd0, 32'sd5);
    send_word(OP_BINARY, 4'd0, 32'sd0);
    // unsorted: -1 sits above zeros, binary probe path misses it
    send_word(OP_WRITE, 4'd9, -32'sd1);
    send_word(OP_LINEAR, 4'd0, -32'sd1);
    send_word(OP_BINARY, 4'd0, -32'sd1);
    send_word(OP_LINEAR, 4'd0, 32'sd0);
    send_word(OP_WRITE, 4'd9, 32'sh5555_AAAA);
    send_word(OP_LINEAR, 4'd6, 32'sh5555_AAAA);
    wait_drained();
  endtask

  task automatic test_receiver_hold();
    calm = 1'b1;
    -> hold_ev;
    for (int n = 0; n < 40; n++) begin
      if ($urandom_range(0, 2) == 0) send_word(OP_WRITE, IDX_W'($urandom), KEY_W'($urandom));
      else send_search(pick_key());
    end
    calm = 1'b0;
    wait_drained();
  endtask

  task automatic load_sorted_table();
    int vals [ENTRIES];
    int mode;
    int hold_val;
    int j;
    mode = $urandom_range(0, 2);
    for (int i = 0; i < ENTRIES; i++) begin
      case (mode)
        0: vals[i] = $urandom;
        1: vals[i] = $urandom_range(0, 12) - 6;
        default: begin
          case ($urandom_range(0, 4))
            0: vals[i] = 32'sh8000_0000;
            1: vals[i] = 32'sh7FFF_FFFF;
            2: vals[i] = -1;
            3: vals[i] = $urandom_range(0, 2);
            default: vals[i] = $urandom;
          endcase
        end
      endcase
    end
    for (int i = 1; i < ENTRIES; i++) begin
      hold_val = vals[i];
      j = i - 1;
      while (j >= 0 && vals[j] > hold_val) begin
        vals[j + 1] = vals[j];
        j--;
      end
      vals[j + 1] = hold_val;
    end
    for (int i = 0; i < ENTRIES; i++) send_word(OP_WRITE, i[IDX_W-1:0], vals[i]);
  endtask

  task automatic test_random_traffic();
    int kind;
    while (words_sent < RANDOM_WORDS) begin
      calm = (words_sent > 500 && words_sent < 650);
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        load_sorted_table();
        repeat ($urandom_range(12, 24)) send_search(pick_key());
      end else if (kind < 8) begin
        repeat ($urandom_range(4, 10))
          send_word(OP_WRITE, IDX_W'($urandom), KEY_W'($urandom));
        repeat ($urandom_range(6, 14)) send_search(pick_key());
      end else begin
        repeat ($urandom_range(10, 20))
          send_word(OP_W'($urandom), IDX_W'($urandom), KEY_W'($urandom));
      end
    end
    calm = 1'b0;
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < ENTRIES; i++) shadow_table[i] = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    test_cleared_table();
    test_extremes_and_unsorted();
    test_receiver_hold();
    test_random_traffic();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
